### src/jads_pkg.sv
package jads_pkg;

  // Window length, ADC width and input clamp range.
  localparam int WINDOW      = 5;
  localparam int SAMPLE_BITS = 12;
  localparam int RANGE       = 2000;

  // Output span: positions run from -OUT_SPAN to OUT_SPAN.
  localparam int OUT_SPAN = 100;

  // Register and field widths fixed by the interface.
  localparam int DZ_W       = 10;
  localparam int POS_W      = 8;
  localparam int DZ_RESET   = 50;

  // Ring slot pointer.
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  // Window sum and its division by WINDOW through a reciprocal multiply.
  localparam int    SUM_W     = SAMPLE_BITS + $clog2(WINDOW);
  localparam int    DIV_SH    = SUM_W + $clog2(WINDOW);
  localparam longint DIV_RECIP = ((longint'(1) << DIV_SH) + WINDOW - 1) / WINDOW;

  // Shifted value u = v + RANGE lies in 0 .. 2*RANGE.
  localparam int U_W = $clog2(2 * RANGE + 1);

  // Scaled value u * OUT_SPAN, then division by RANGE through a reciprocal.
  localparam int     SPAN_W    = $clog2(2 * OUT_SPAN * RANGE + 1);
  localparam int     MAP_SH    = SPAN_W + $clog2(RANGE);
  localparam longint MAP_RECIP = ((longint'(1) << MAP_SH) + RANGE - 1) / RANGE;

  // Shared multiplier operand widths.
  localparam int OPA_W  = (SUM_W > SPAN_W) ? SUM_W : SPAN_W;
  localparam int OPB_W  = (DIV_SH > SPAN_W) ? DIV_SH + 1 : SPAN_W + 1;
  localparam int PROD_W = OPA_W + OPB_W;

  // Signed width for the centre subtraction, clamp and dead zone.
  localparam int D_BASE = (SAMPLE_BITS > U_W) ? SAMPLE_BITS : U_W;
  localparam int D_W    = ((D_BASE > DZ_W) ? D_BASE : DZ_W) + 2;

  // Axis codes.
  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;

endpackage

### src/jads_window.sv
module jads_window (
  input  logic                               clk,
  input  logic                               wr_en,
  input  logic [jads_pkg::SLOT_W-1:0]        wr_slot,
  input  logic [jads_pkg::SAMPLE_BITS-1:0]   wr_x,
  input  logic [jads_pkg::SAMPLE_BITS-1:0]   wr_y,
  input  logic                               rd_axis,
  input  logic [jads_pkg::SLOT_W-1:0]        rd_slot,
  output logic [jads_pkg::SAMPLE_BITS-1:0]   rd_data
);
  import jads_pkg::*;

  logic [SAMPLE_BITS-1:0] x_win_r [WINDOW];
  logic [SAMPLE_BITS-1:0] y_win_r [WINDOW];

  // Both axes are written in the same beat at the shared ring slot.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      x_win_r[wr_slot] <= wr_x;
      y_win_r[wr_slot] <= wr_y;
    end
  end

  // One read port, walked slot by slot by the summing sequence.
  always_comb begin
    if (rd_axis == AXIS_Y) begin
      rd_data = y_win_r[rd_slot];
    end else begin
      rd_data = x_win_r[rd_slot];
    end
  end

endmodule

### src/jads_mul.sv
module jads_mul (
  input  logic                          clk,
  input  logic [jads_pkg::OPA_W-1:0]    op_a,
  input  logic [jads_pkg::OPB_W-1:0]    op_b,
  output logic [jads_pkg::PROD_W-1:0]   prod_r
);
  import jads_pkg::*;

  // Shared unsigned multiplier with a registered product.
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(op_a) * PROD_W'(op_b);
  end

endmodule

### src/joystick_average_deadzone_scaler_unit.sv
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid / in_ready   | in_x_sample, in_y_sample
// out     | output    | out_valid / out_ready | out_x_position, out_y_position, out_ready_res
// cfg     | input     | cfg_valid / cfg_ready | cfg_data (dead zone)
//
// An item is taken only in the idle state. Before the windows first fill, the
// item goes straight to the emit state and its result then leaves through
// the output register. Afterwards each axis in turn is summed slot by slot
// over the window and then passes through the divide, shape, span, map and
// store steps on the one shared multiplier, and the result leaves through the
// emit state; the next item is taken only once the sequencer is idle again.
// Reset is synchronous and active low. A finished result waits in the output
// register while a stalled consumer holds out_ready low; the sequencer waits
// only if a new result is ready before the old one has been taken.
module joystick_average_deadzone_scaler_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [jads_pkg::SAMPLE_BITS-1:0]    in_x_sample,
  input  logic [jads_pkg::SAMPLE_BITS-1:0]    in_y_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [jads_pkg::POS_W-1:0]   out_x_position,
  output logic signed [jads_pkg::POS_W-1:0]   out_y_position,
  output logic                                out_ready_res,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [jads_pkg::DZ_W-1:0]           cfg_data
);
  import jads_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SUM   = 8'b0000_0010,
    S_DIV   = 8'b0000_0100,
    S_SHAPE = 8'b0000_1000,
    S_SPAN  = 8'b0001_0000,
    S_MAP   = 8'b0010_0000,
    S_STORE = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

  localparam logic signed [D_W-1:0] RANGE_D = D_W'(RANGE);

  state_t                   state_r, state_nxt;
  logic [SLOT_W-1:0]        slot_r, slot_nxt;
  logic [SLOT_W-1:0]        idx_r, idx_nxt;
  logic                     axis_r, axis_nxt;
  logic                     running_r, running_nxt;
  logic                     latch_r, latch_nxt;
  logic [SUM_W-1:0]         acc_r, acc_nxt;
  logic [U_W-1:0]           u_r, u_nxt;
  logic [SAMPLE_BITS-1:0]   x_centre_r, x_centre_nxt;
  logic [SAMPLE_BITS-1:0]   y_centre_r, y_centre_nxt;
  logic [POS_W-1:0]         x_held_r, x_held_nxt;
  logic [POS_W-1:0]         y_held_r, y_held_nxt;
  logic [DZ_W-1:0]          dead_zone_r, dead_zone_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]         out_x_r, out_x_nxt;
  logic [POS_W-1:0]         out_y_r, out_y_nxt;
  logic                     out_res_r, out_res_nxt;

  logic                     in_beat;
  logic                     out_free;
  logic [SAMPLE_BITS-1:0]   rd_data;
  logic [OPA_W-1:0]         op_a;
  logic [OPB_W-1:0]         op_b;
  logic [PROD_W-1:0]        prod_r;
  logic [SAMPLE_BITS-1:0]   avg;
  logic [SAMPLE_BITS-1:0]   centre;
  logic signed [D_W-1:0]    diff;
  logic signed [D_W-1:0]    clamped;
  logic signed [D_W-1:0]    shrunk;
  logic signed [D_W-1:0]    dz_d;
  logic [POS_W-1:0]         quot;
  logic [POS_W-1:0]         pos;

  assign in_ready  = (state_r == S_IDLE);
  assign in_beat   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_x_position = out_x_r;
  assign out_y_position = out_y_r;
  assign out_ready_res  = out_res_r;

  // Sample windows for both axes.
  jads_window u_window (
    .clk     (clk),
    .wr_en   (in_beat),
    .wr_slot (slot_r),
    .wr_x    (in_x_sample),
    .wr_y    (in_y_sample),
    .rd_axis (axis_r),
    .rd_slot (idx_r),
    .rd_data (rd_data)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    op_a = OPA_W'(acc_r);
    op_b = OPB_W'(DIV_RECIP);
    case (state_r)
      S_SPAN: begin
        op_a = OPA_W'(u_r);
        op_b = OPB_W'(OUT_SPAN);
      end
      S_MAP: begin
        op_a = OPA_W'(prod_r[SPAN_W-1:0]);
        op_b = OPB_W'(MAP_RECIP);
      end
      default: begin
        op_a = OPA_W'(acc_r);
        op_b = OPB_W'(DIV_RECIP);
      end
    endcase
  end

  jads_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  // Centre subtraction, clamp to the range and dead zone removal.
  always_comb begin
    avg    = prod_r[DIV_SH +: SAMPLE_BITS];
    if (latch_r) begin
      centre = avg;
    end else if (axis_r == AXIS_Y) begin
      centre = y_centre_r;
    end else begin
      centre = x_centre_r;
    end
    dz_d = D_W'(dead_zone_r);
    diff = D_W'(avg) - D_W'(centre);
    if (diff > RANGE_D) begin
      clamped = RANGE_D;
    end else if (diff < -RANGE_D) begin
      clamped = -RANGE_D;
    end else begin
      clamped = diff;
    end
    if (clamped > dz_d) begin
      shrunk = clamped - dz_d;
    end else if (clamped < -dz_d) begin
      shrunk = clamped + dz_d;
    end else begin
      shrunk = '0;
    end
  end

  // Quotient of the map lies in 0 .. 2*OUT_SPAN; recentre it.
  assign quot = prod_r[MAP_SH +: POS_W];
  assign pos  = quot - POS_W'(OUT_SPAN);

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    idx_nxt       = idx_r;
    axis_nxt      = axis_r;
    running_nxt   = running_r;
    latch_nxt     = latch_r;
    acc_nxt       = acc_r;
    u_nxt         = u_r;
    x_centre_nxt  = x_centre_r;
    y_centre_nxt  = y_centre_r;
    x_held_nxt    = x_held_r;
    y_held_nxt    = y_held_r;
    dead_zone_nxt = dead_zone_r;
    out_valid_nxt = out_valid_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_res_nxt   = out_res_r;

    if (cfg_valid && cfg_ready) begin
      dead_zone_nxt = cfg_data;
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          slot_nxt = (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : slot_r + 1'b1;
          latch_nxt = !running_r && (slot_r == SLOT_W'(WINDOW - 1));
          if (running_r || latch_nxt) begin
            running_nxt = 1'b1;
            axis_nxt    = AXIS_X;
            idx_nxt     = '0;
            acc_nxt     = '0;
            state_nxt   = S_SUM;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_SUM: begin
        acc_nxt = acc_r + SUM_W'(rd_data);
        if (idx_r == SLOT_W'(WINDOW - 1)) begin
          state_nxt = S_DIV;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DIV: begin
        state_nxt = S_SHAPE;
      end
      S_SHAPE: begin
        if (latch_r) begin
          if (axis_r == AXIS_Y) begin
            y_centre_nxt = avg;
          end else begin
            x_centre_nxt = avg;
          end
        end
        u_nxt     = U_W'(shrunk + RANGE_D);
        state_nxt = S_SPAN;
      end
      S_SPAN: begin
        state_nxt = S_MAP;
      end
      S_MAP: begin
        state_nxt = S_STORE;
      end
      S_STORE: begin
        if (axis_r == AXIS_Y) begin
          y_held_nxt = pos;
          state_nxt  = S_EMIT;
        end else begin
          x_held_nxt = pos;
          axis_nxt   = AXIS_Y;
          idx_nxt    = '0;
          acc_nxt    = '0;
          state_nxt  = S_SUM;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = x_held_r;
          out_y_nxt     = y_held_r;
          out_res_nxt   = running_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slot_r      <= '0;
      idx_r       <= '0;
      axis_r      <= AXIS_X;
      running_r   <= 1'b0;
      latch_r     <= 1'b0;
      x_centre_r  <= '0;
      y_centre_r  <= '0;
      x_held_r    <= '0;
      y_held_r    <= '0;
      dead_zone_r <= DZ_W'(DZ_RESET);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      idx_r       <= idx_nxt;
      axis_r      <= axis_nxt;
      running_r   <= running_nxt;
      latch_r     <= latch_nxt;
      x_centre_r  <= x_centre_nxt;
      y_centre_r  <= y_centre_nxt;
      x_held_r    <= x_held_nxt;
      y_held_r    <= y_held_nxt;
      dead_zone_r <= dead_zone_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    acc_r     <= acc_nxt;
    u_r       <= u_nxt;
    out_x_r   <= out_x_nxt;
    out_y_r   <= out_y_nxt;
    out_res_r <= out_res_nxt;
  end

endmodule
